FILE: rtl/core/ps2hl_pkg.sv
// Shared types, opcodes and sizes for the PS/2 host link with receive FIFO.
package ps2hl_pkg;

    // Event codes carried in the input beat's tuser
    localparam logic [1:0] OP_CLK_EDGE = 2'd0;
    localparam logic [1:0] OP_SEND     = 2'd1;
    localparam logic [1:0] OP_POP      = 2'd2;

    // Frame bit positions
    localparam logic [3:0] POS_FIRST   = 4'd1;
    localparam logic [3:0] POS_DATA_HI = 4'd8;
    localparam logic [3:0] POS_RX_LO   = 4'd2;
    localparam logic [3:0] POS_RX_HI   = 4'd9;
    localparam logic [3:0] POS_PARITY  = 4'd9;
    localparam logic [3:0] POS_STOP    = 4'd10;
    localparam logic [3:0] POS_ACK     = 4'd11;

    // Receive FIFO sizing
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int LEVEL_W    = 5;

    // Line and transfer status after one event
    typedef struct packed {
        logic drive_enable;
        logic drive_level;
        logic busy;
        logic done;
        logic accepted;
    } t_link_stat;

    // Completed receive frame headed for the FIFO
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_rx_push;

endpackage

FILE: rtl/core/ps2_host_link_with_receive_fifo_unit.sv
// Top level of the PS/2 host link with receive FIFO: beat registers and result register.
//
//  Channel   Dir  Beat accepted when              Payload
//  --------  ---  ------------------------------  ----------------------------------------
//  s_axis    in   s_axis_tvalid & s_axis_tready   tuser: opcode; tdata: line, send byte
//  m_axis    out  m_axis_tvalid & m_axis_tready   tdata: line drive, status, popped byte
//
// One event per cycle while the output is not stalled: an input beat is registered in
// the input beat register, processed by the frame sequencer and FIFO when the result
// register is free or draining, and its result lands in the output register. The FIFO
// store read is registered in the FIFO and drives the result's byte field. Synchronous
// active-low reset clears all control state; FIFO contents stay undefined. A stalled output
// holds its result and the input register keeps one more beat before s_axis_tready falls.
module ps2_host_link_with_receive_fifo_unit
    import ps2hl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [0] data_line, [8:1] send_byte, [15:9] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [0] drive_enable, [1] drive_level,
                                        // [2] busy_sending, [3] send_done,
                                        // [4] request_accepted, [5] byte_valid,
                                        // [13:6] byte_value, [18:14] fifo_level,
                                        // [23:19] zero
);

    // Input beat register
    logic               r_in_valid;
    logic [1:0]         r_in_op;
    logic               r_in_line;
    logic [7:0]         r_in_byte;

    // Result register
    logic               r_out_valid;
    t_link_stat         r_stat;
    logic               r_byte_valid;
    logic [LEVEL_W-1:0] r_level;

    logic               w_adv;
    t_link_stat         w_stat;
    t_rx_push           w_push;
    t_rx_push           w_push_q;
    logic               w_pop;
    logic               w_pop_ok;
    logic [7:0]         w_rd_data;
    logic [FIFO_CW-1:0] w_count_next;
    logic [FIFO_CW+LEVEL_W-1:0] w_count_ext;

    // Process the held beat when the result register is free or draining
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tuser;
            r_in_line <= s_axis_tdata[0];
            r_in_byte <= s_axis_tdata[8:1];
        end
    end

    ps2hl_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_adv),
        .i_opcode    (r_in_op),
        .i_data_line (r_in_line),
        .i_send_byte (r_in_byte),
        .o_stat      (w_stat),
        .o_push      (w_push)
    );

    assign w_push_q = '{valid: w_push.valid && w_adv, data: w_push.data};
    assign w_pop    = w_adv && (r_in_op == OP_POP);

    ps2hl_rxfifo u_rxfifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push_q),
        .i_pop        (w_pop),
        .o_pop_ok     (w_pop_ok),
        .o_rd_data    (w_rd_data),
        .o_count_next (w_count_next)
    );

    // Fill level reported masked to the field width
    assign w_count_ext = {{LEVEL_W{1'b0}}, w_count_next};

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_stat       <= w_stat;
            r_byte_valid <= w_pop && w_pop_ok;
            r_level      <= w_count_ext[LEVEL_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0,
                            r_level,
                            r_byte_valid ? w_rd_data : 8'd0,
                            r_byte_valid,
                            r_stat.accepted,
                            r_stat.done,
                            r_stat.busy,
                            r_stat.drive_level,
                            r_stat.drive_enable};

endmodule

FILE: rtl/core/ps2hl_frame.sv
// Frame sequencer: bit position, shift byte, parity count and data line drive.
module ps2hl_frame
    import ps2hl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,          // one event is processed this cycle
    input  logic [1:0] i_opcode,
    input  logic       i_data_line,
    input  logic [7:0] i_send_byte,
    output t_link_stat o_stat,        // status after this event
    output t_rx_push   o_push         // received byte to store
);

    logic [3:0] r_pos, n_pos;
    logic [3:0] r_ones, n_ones;
    logic [7:0] r_shift, n_shift;
    logic       r_sending, n_sending;
    logic       r_drv_en, n_drv_en;
    logic       r_drv_lvl, n_drv_lvl;
    logic       w_done, w_accepted;
    logic [3:0] w_pos_m1, w_pos_m2;
    logic       w_tx_bit;

    assign w_pos_m1 = r_pos - 4'd1;
    assign w_pos_m2 = r_pos - 4'd2;

    // Data bit to drive at the current position (0 outside the data bits)
    assign w_tx_bit = (r_pos >= POS_FIRST && r_pos <= POS_DATA_HI) ?
                      r_shift[w_pos_m1[2:0]] : 1'b0;

    // Next state for one event
    always_comb begin
        n_pos       = r_pos;
        n_ones      = r_ones;
        n_shift     = r_shift;
        n_sending   = r_sending;
        n_drv_en    = r_drv_en;
        n_drv_lvl   = r_drv_lvl;
        w_done      = 1'b0;
        w_accepted  = 1'b0;
        o_push      = '{valid: 1'b0, data: r_shift};
        case (i_opcode)
            OP_CLK_EDGE: begin
                if (r_sending) begin
                    if (r_pos == POS_PARITY) begin
                        n_drv_lvl = ~r_ones[0];
                    end else if (r_pos == POS_STOP) begin
                        n_drv_lvl = 1'b1;
                    end else if (r_pos == POS_ACK) begin
                        n_shift   = 8'd0;
                        n_sending = 1'b0;
                        n_drv_en  = 1'b0;
                        n_drv_lvl = 1'b1;
                        w_done    = 1'b1;
                    end else begin
                        n_drv_lvl = w_tx_bit;
                        n_ones    = r_ones + {3'd0, w_tx_bit};
                    end
                end else begin
                    if (r_pos >= POS_RX_LO && r_pos <= POS_RX_HI) begin
                        if (i_data_line) begin
                            n_shift[w_pos_m2[2:0]] = 1'b1;
                        end
                    end else if (r_pos == POS_ACK) begin
                        o_push.valid = 1'b1;
                        n_shift      = 8'd0;
                    end
                end
                // position restarts at 0 on the last edge, then advances
                n_pos = (r_pos == POS_ACK) ? 4'd1 : r_pos + 4'd1;
            end
            OP_SEND: begin
                if (!r_sending) begin
                    n_pos      = POS_FIRST;
                    n_ones     = 4'd0;
                    n_shift    = i_send_byte;
                    n_sending  = 1'b1;
                    n_drv_en   = 1'b1;
                    n_drv_lvl  = 1'b0;
                    w_accepted = 1'b1;
                end
            end
            default: begin
            end
        endcase
        o_stat = '{drive_enable: n_drv_en, drive_level: n_drv_lvl, busy: n_sending,
                   done: w_done, accepted: w_accepted};
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_FIRST;
            r_ones    <= 4'd0;
            r_shift   <= 8'd0;
            r_sending <= 1'b0;
            r_drv_en  <= 1'b0;
            r_drv_lvl <= 1'b1;
        end else if (i_en) begin
            r_pos     <= n_pos;
            r_ones    <= n_ones;
            r_shift   <= n_shift;
            r_sending <= n_sending;
            r_drv_en  <= n_drv_en;
            r_drv_lvl <= n_drv_lvl;
        end
    end

endmodule

FILE: rtl/core/ps2hl_rxfifo.sv
// Receive FIFO: byte store with write/read indexes, fill count and registered read.
module ps2hl_rxfifo
    import ps2hl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_rx_push           i_push,      // already qualified by the event strobe
    input  logic               i_pop,       // already qualified by the event strobe
    output logic               o_pop_ok,    // a pop now returns a stored byte
    output logic [7:0]         o_rd_data,   // byte from the last successful pop
    output logic [FIFO_CW-1:0] o_count_next
);

    logic [7:0]         r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_idx, r_rd_idx;
    logic [FIFO_CW-1:0] r_count;
    logic               w_wr, w_rd;

    localparam logic [FIFO_AW-1:0] LAST_IDX = FIFO_AW'(FIFO_DEPTH - 1);
    localparam logic [FIFO_CW-1:0] FULL_CNT = FIFO_CW'(FIFO_DEPTH);

    assign o_pop_ok = (r_count != '0);
    assign w_wr     = i_push.valid && (r_count != FULL_CNT);
    assign w_rd     = i_pop && o_pop_ok;

    // Only one event per cycle, so a push and a pop never meet
    always_comb begin
        o_count_next = r_count;
        if (w_wr) begin
            o_count_next = r_count + FIFO_CW'(1);
        end else if (w_rd) begin
            o_count_next = r_count - FIFO_CW'(1);
        end
    end

    // Byte store, written at the write index, read into a register
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_idx] <= i_push.data;
        end
        if (w_rd) begin
            o_rd_data <= r_mem[r_rd_idx];
        end
    end

    // Indexes and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_idx <= (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + FIFO_AW'(1);
            end
            if (w_rd) begin
                r_rd_idx <= (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + FIFO_AW'(1);
            end
            r_count <= o_count_next;
        end
    end

endmodule

FILE: test/ps2hl_result_checker.sv
// Result checker for the PS/2 host link: predicts each status beat and compares it.
`timescale 1ns / 100ps

module ps2hl_result_checker
    import ps2hl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [0] data_line, [8:1] send_byte, [15:9] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [0] drive_enable, [1] drive_level,
                                        // [2] busy_sending, [3] send_done,
                                        // [4] request_accepted, [5] byte_valid,
                                        // [13:6] byte_value, [18:14] fifo_level,
                                        // [23:19] zero
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    // Status beat layout, highest field first
    typedef struct packed {
        logic [LEVEL_W-1:0] fifo_level;
        logic [7:0]         byte_value;
        logic               byte_valid;
        logic               accepted;
        logic               done;
        logic               busy;
        logic               drv_level;
        logic               drv_enable;
    } t_link_status;

    // Shadow copy of the link state
    logic [3:0]          bit_pos;
    logic [3:0]          ones_cnt;
    logic [7:0]          frame_byte;
    logic                sending;
    logic                line_en;
    logic                line_lvl;
    logic [7:0]          rx_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr;
    logic [FIFO_AW-1:0]  rd_ptr;
    logic [FIFO_CW-1:0]  fill;

    t_link_status awaited_status [$];
    int fail_total  = 0;
    int checked     = 0;
    int pending_cnt = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_cnt;
    assign o_checked    = checked;

    // Apply one event to the shadow state and return the status it leaves
    function automatic t_link_status advance_link(logic [1:0] op, logic line,
                                                  logic [7:0] tx_byte);
        t_link_status st;
        logic         data_bit;
        st = '0;
        case (op)
            OP_CLK_EDGE: begin
                if (sending) begin
                    if (bit_pos == POS_PARITY) begin
                        line_lvl = ~ones_cnt[0];
                    end else if (bit_pos == POS_STOP) begin
                        line_lvl = 1'b1;
                    end else if (bit_pos == POS_ACK) begin
                        // acknowledge edge: release the line, send over
                        frame_byte = '0;
                        bit_pos    = '0;
                        sending    = 1'b0;
                        line_en    = 1'b0;
                        line_lvl   = 1'b1;
                        st.done    = 1'b1;
                    end else begin
                        data_bit = 1'b0;
                        if (bit_pos >= POS_FIRST && bit_pos <= POS_DATA_HI)
                            data_bit = frame_byte[bit_pos - POS_FIRST];
                        line_lvl = data_bit;
                        if (data_bit)
                            ones_cnt = ones_cnt + 4'd1;
                    end
                end else begin
                    if (bit_pos >= POS_RX_LO && bit_pos <= POS_RX_HI) begin
                        if (line)
                            frame_byte[bit_pos - POS_RX_LO] = 1'b1;
                    end else if (bit_pos == POS_ACK) begin
                        // frame complete; dropped when the FIFO is full
                        if (fill < FIFO_DEPTH) begin
                            rx_mem[wr_ptr] = frame_byte;
                            wr_ptr = (wr_ptr == FIFO_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
                            fill   = fill + 1'b1;
                        end
                        frame_byte = '0;
                        bit_pos    = '0;
                    end
                end
                bit_pos = bit_pos + 4'd1;
            end
            OP_SEND: begin
                if (!sending) begin
                    bit_pos     = POS_FIRST;
                    ones_cnt    = '0;
                    frame_byte  = tx_byte;
                    sending     = 1'b1;
                    line_en     = 1'b1;
                    line_lvl    = 1'b0;
                    st.accepted = 1'b1;
                end
            end
            OP_POP: begin
                if (fill != 0) begin
                    st.byte_value = rx_mem[rd_ptr];
                    st.byte_valid = 1'b1;
                    rd_ptr = (rd_ptr == FIFO_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
                    fill   = fill - 1'b1;
                end
            end
            default: ;  // unused code: status only
        endcase
        st.drv_enable = line_en;
        st.drv_level  = line_lvl;
        st.busy       = sending;
        st.fifo_level = fill[LEVEL_W-1:0];
        return st;
    endfunction

    task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            fail_total++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // Watch both channels at the rising edge
    always @(posedge i_clk) begin
        t_link_status want;
        t_link_status got;
        if (!i_rst_n) begin
            bit_pos    = POS_FIRST;
            ones_cnt   = '0;
            frame_byte = '0;
            sending    = 1'b0;
            line_en    = 1'b0;
            line_lvl   = 1'b1;
            wr_ptr     = '0;
            rd_ptr     = '0;
            fill       = '0;
            awaited_status.delete();
        end else begin
            // output beat against the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_link_status'(m_axis_tdata[$bits(t_link_status)-1:0]);
                if (awaited_status.size() == 0) begin
                    fail_total++;
                    $display("%0t ns: beat %h arrived, expected none", $time,
                             m_axis_tdata);
                end else begin
                    want = awaited_status.pop_front();
                    checked++;
                    compare_field("drive_enable", want.drv_enable, got.drv_enable);
                    compare_field("drive_level", want.drv_level, got.drv_level);
                    compare_field("busy_sending", want.busy, got.busy);
                    compare_field("send_done", want.done, got.done);
                    compare_field("request_accepted", want.accepted, got.accepted);
                    compare_field("byte_valid", want.byte_valid, got.byte_valid);
                    compare_field("byte_value", want.byte_value, got.byte_value);
                    compare_field("fifo_level", want.fifo_level, got.fifo_level);
                end
            end
            // input beat feeds the predictor
            if (s_axis_tvalid && s_axis_tready)
                awaited_status.push_back(advance_link(s_axis_tuser, s_axis_tdata[0],
                                                      s_axis_tdata[8:1]));
        end
        pending_cnt = awaited_status.size();
    end

endmodule

FILE: test/tb_ps2_host_link_with_receive_fifo_unit.sv
// Testbench top for the PS/2 host link: clock, reset, event stimulus and verdict.
`timescale 1ns / 100ps

module tb_ps2_host_link_with_receive_fifo_unit;
    import ps2hl_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;   // unused event code
    localparam int EVENT_TARGET = 1150;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 100000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // [0] data_line, [8:1] send_byte, [15:9] zero
    logic [1:0]  s_axis_tuser  = '0;    // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [0] drive_enable, [1] drive_level,
                                        // [2] busy_sending, [3] send_done,
                                        // [4] request_accepted, [5] byte_valid,
                                        // [13:6] byte_value, [18:14] fifo_level,
                                        // [23:19] zero

    int  fail_count;
    int  pending;
    int  checked;
    int  cycle_count    = 0;
    int  n_events       = 0;
    int  stall_requests = 0;
    logic calm          = 1'b0;

    always #5 i_clk = ~i_clk;

    ps2_host_link_with_receive_fifo_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ps2hl_result_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random backpressure, plus a long hold-off on request
    initial begin
        int served;
        served = 0;
        forever begin
            @(negedge i_clk);
            if (served < stall_requests) begin
                served++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 21);
        end
    end

    // Offer one event beat; entered and left at a falling edge
    task automatic offer_event(logic [1:0] op, logic line, logic [7:0] tx_byte);
        while (!calm && $urandom_range(99) < 21) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, tx_byte, line};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        n_events++;
    endtask

    // Stop offering until every predicted beat has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    // Stimulus
    initial begin
        int         pick;
        int         frame_len;
        int         pop_pct;
        int         rx_frames;
        int         tx_frames;
        int         pops;
        int         noise;
        logic       stalled;
        logic       paused;
        logic       lvl;
        logic [7:0] rx_byte;
        rx_frames = 0;
        tx_frames = 0;
        pops      = 0;
        noise     = 0;
        stalled   = 1'b0;
        paused    = 1'b0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty pop, unused code, send over a half frame, busy refusal
        offer_event(OP_POP, 1'b1, 8'hFF);
        offer_event(OP_NOP, 1'b1, 8'hFF);
        for (int k = 0; k < 5; k++)
            offer_event(OP_CLK_EDGE, k[0], 8'h00);
        offer_event(OP_SEND, 1'b0, 8'hFF);
        offer_event(OP_SEND, 1'b1, 8'h00);
        for (int k = 0; k < 11; k++)
            offer_event(OP_CLK_EDGE, k[0], 8'h5A);
        offer_event(OP_POP, 1'b0, 8'h00);
        wait_drained();

        // Random: mostly well-formed frames, with pops, refusals and noise
        while (n_events < EVENT_TARGET) begin
            // no pops mid-run so the FIFO overflows, then drain it hard
            pop_pct = (n_events >= 300 && n_events < 600) ? 0 :
                      (n_events >= 600 && n_events < 800) ? 45 : 20;
            calm = (n_events >= 850 && n_events < 1000);
            if (!stalled && n_events >= 400) begin
                stalled = 1'b1;
                stall_requests++;
            end
            if (!paused && n_events >= 700) begin
                paused = 1'b1;
                wait_drained();
            end
            pick = $urandom_range(99);
            if (pick < pop_pct) begin
                repeat ($urandom_range(1, 5)) begin
                    offer_event(OP_POP, 1'($urandom), 8'($urandom));
                    pops++;
                end
            end else if (pick < pop_pct + 12) begin
                repeat ($urandom_range(1, 4)) begin
                    offer_event(2'($urandom_range(3)), 1'($urandom), 8'($urandom));
                    noise++;
                end
            end else if (pick < pop_pct + 28) begin
                // host send, sometimes with a refused second request
                offer_event(OP_SEND, 1'($urandom), 8'($urandom));
                if ($urandom_range(3) == 0)
                    offer_event(OP_SEND, 1'($urandom), 8'($urandom));
                repeat (11)
                    offer_event(OP_CLK_EDGE, 1'($urandom), 8'($urandom));
                tx_frames++;
            end else begin
                // device frame: start, data LSB first, odd parity, stop
                rx_byte   = 8'($urandom);
                frame_len = ($urandom_range(9) == 0) ? $urandom_range(1, 10) : 11;
                for (int k = 0; k < frame_len; k++) begin
                    case (k)
                        0:       lvl = 1'b0;
                        9:       lvl = ~^rx_byte;
                        10:      lvl = 1'b1;
                        default: lvl = rx_byte[k-1];
                    endcase
                    offer_event(OP_CLK_EDGE, lvl, 8'($urandom));
                end
                rx_frames++;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Ran %0d events: %0d device frames, %0d host sends, %0d pop beats, %0d mixed",
                 n_events, rx_frames, tx_frames, pops, noise);
        $display("Checked %0d status beats, with FIFO overflow, drain and a long output stall",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/ps2hl_pkg.sv
rtl/core/ps2hl_frame.sv
rtl/core/ps2hl_rxfifo.sv
rtl/core/ps2_host_link_with_receive_fifo_unit.sv
test/ps2hl_result_checker.sv
test/tb_ps2_host_link_with_receive_fifo_unit.sv
